/* rtl/phk_pkg.sv */
// Shared constants, CORDIC angle table and saturation helpers for the kinematics block.
`default_nettype none

package phk_pkg;

	localparam int TRIG_BITS_DEF = 16;
	localparam int CORDIC_STEPS  = 30;
	localparam int CORDIC_FRAC   = 30;
	localparam int CORDIC_XW     = 33;
	localparam int CORDIC_ZW     = 34;
	localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN = 33'sd652032874;
	// Front pipeline: fold register, one register per rotation, rounding register
	localparam int FRONT_LAT     = CORDIC_STEPS + 2;
	localparam int QUEUE_DEPTH   = 4;

	localparam int SPEED_W = 19;
	localparam int ANGLE_W = 16;
	localparam int RATE_W  = 24;
	localparam int VEL_W   = 20;
	localparam int ACC_W   = 32;
	localparam int ACC_SH  = 16;

	localparam logic signed [31:0] VEL_MAX = 32'sd524287;
	localparam logic signed [31:0] VEL_MIN = -32'sd524288;
	localparam logic signed [63:0] ACC_MAX = 64'sd2147483647;
	localparam logic signed [63:0] ACC_MIN = -64'sd2147483648;

	// Arctangent of 2^-i in units of 2^32 per turn
	function automatic logic [31:0] atan_phase(input int i);
		logic [31:0] v;
		case (i)
			0: v = 32'd536870912;
			1: v = 32'd316933406;
			2: v = 32'd167458907;
			3: v = 32'd85004756;
			4: v = 32'd42667331;
			5: v = 32'd21354465;
			6: v = 32'd10679838;
			7: v = 32'd5340245;
			8: v = 32'd2670163;
			9: v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41722;
			15: v = 32'd20861;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2608;
			19: v = 32'd1304;
			20: v = 32'd652;
			21: v = 32'd326;
			22: v = 32'd163;
			23: v = 32'd81;
			24: v = 32'd41;
			25: v = 32'd20;
			26: v = 32'd10;
			27: v = 32'd5;
			28: v = 32'd3;
			29: v = 32'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Clamp a velocity to the 20-bit field
	function automatic logic [VEL_W-1:0] sat_vel(input logic signed [31:0] v);
		logic [VEL_W-1:0] r;
		if (v > VEL_MAX) begin
			r = VEL_MAX[VEL_W-1:0];
		end else if (v < VEL_MIN) begin
			r = VEL_MIN[VEL_W-1:0];
		end else begin
			r = v[VEL_W-1:0];
		end
		return r;
	endfunction

	// Clamp an acceleration to 32 bits; top bit of the result flags a clamp
	function automatic logic [ACC_W:0] sat_acc(input logic signed [63:0] v);
		logic [ACC_W:0] r;
		if (v > ACC_MAX) begin
			r = {1'b1, ACC_MAX[ACC_W-1:0]};
		end else if (v < ACC_MIN) begin
			r = {1'b1, ACC_MIN[ACC_W-1:0]};
		end else begin
			r = {1'b0, v[ACC_W-1:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/pitch_heading_kinematics.sv */
// Top level of the speed/pitch/heading to NED velocity and acceleration block.
//
// Input channel: in_valid/in_stall with speed, pitch_angle, heading_angle,
// pitch_rate and heading_rate; a transfer happens when in_valid is high and
// in_stall low at a rising clk edge. Output channel: out_valid/out_stall with
// the three velocities, three accelerations and the saturated flag.
// Each input transfer gives exactly one output transfer, in order.
// Throughput: one item per cycle while nothing stalls, set by the fully
// pipelined CORDIC front end (two units, one stage per rotation) and the
// multiply back end. When nothing stalls, the input transfer loads the first
// of 32 front stages, then one queue slot and 7 back stages follow before
// out_valid. A four-entry queue separates the two halves. When out_stall
// holds against a valid output, the back end freezes; the front keeps
// accepting until the queue is full and an item waits at the front's end,
// then raises in_stall. Reset (arst_n low) empties the pipeline and the
// queue; no item state survives, and no configuration exists.
`default_nettype none

module pitch_heading_kinematics #(
	parameter int TRIG_BITS = phk_pkg::TRIG_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [phk_pkg::SPEED_W-1:0]        speed,
	input  wire logic signed [phk_pkg::ANGLE_W-1:0] pitch_angle,
	input  wire logic signed [phk_pkg::ANGLE_W-1:0] heading_angle,
	input  wire logic signed [phk_pkg::RATE_W-1:0]  pitch_rate,
	input  wire logic signed [phk_pkg::RATE_W-1:0]  heading_rate,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [phk_pkg::VEL_W-1:0]        vel_north,
	output logic signed [phk_pkg::VEL_W-1:0]        vel_east,
	output logic signed [phk_pkg::VEL_W-1:0]        vel_down,
	output logic signed [phk_pkg::ACC_W-1:0]        acc_north,
	output logic signed [phk_pkg::ACC_W-1:0]        acc_east,
	output logic signed [phk_pkg::ACC_W-1:0]        acc_down,
	output logic                                    saturated
);

	localparam int W  = TRIG_BITS + 2;
	localparam int DW = phk_pkg::SPEED_W + 4 * W + 2 * phk_pkg::RATE_W;

	logic                              push, pop, q_full, q_empty;
	logic [phk_pkg::SPEED_W-1:0]       f_speed, h_speed;
	logic signed [W-1:0]               f_sp, f_cp, f_sh, f_ch;
	logic signed [W-1:0]               h_sp, h_cp, h_sh, h_ch;
	logic signed [phk_pkg::RATE_W-1:0] f_q, f_r, h_q, h_r;
	logic [DW-1:0]                     wdata, rdata;

	phk_front #(.TRIG_BITS(TRIG_BITS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.speed         (speed),
		.pitch_angle   (pitch_angle),
		.heading_angle (heading_angle),
		.pitch_rate    (pitch_rate),
		.heading_rate  (heading_rate),
		.q_full        (q_full),
		.push          (push),
		.f_speed       (f_speed),
		.f_sp          (f_sp),
		.f_cp          (f_cp),
		.f_sh          (f_sh),
		.f_ch          (f_ch),
		.f_q           (f_q),
		.f_r           (f_r)
	);

	// Pack and unpack queue entries
	assign wdata = {f_speed, f_sp, f_cp, f_sh, f_ch, f_q, f_r};
	assign {h_speed, h_sp, h_cp, h_sh, h_ch, h_q, h_r} = rdata;

	phk_queue #(.DW(DW), .DEPTH(phk_pkg::QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.pop    (pop),
		.rdata  (rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	phk_back #(.TRIG_BITS(TRIG_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.pop       (pop),
		.h_speed   (h_speed),
		.h_sp      (h_sp),
		.h_cp      (h_cp),
		.h_sh      (h_sh),
		.h_ch      (h_ch),
		.h_q       (h_q),
		.h_r       (h_r),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.vel_north (vel_north),
		.vel_east  (vel_east),
		.vel_down  (vel_down),
		.acc_north (acc_north),
		.acc_east  (acc_east),
		.acc_down  (acc_down),
		.saturated (saturated)
	);

endmodule

`default_nettype wire

/* rtl/phk_cordic.sv */
// Pipelined rotation-mode CORDIC giving sine and cosine of a binary angle.
`default_nettype none

module phk_cordic #(
	parameter int TRIG_BITS = phk_pkg::TRIG_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic signed [15:0]         angle,
	output logic signed [TRIG_BITS+1:0]     sin_val,
	output logic signed [TRIG_BITS+1:0]     cos_val
);

	localparam int N  = phk_pkg::CORDIC_STEPS;
	localparam int XW = phk_pkg::CORDIC_XW;
	localparam int ZW = phk_pkg::CORDIC_ZW;
	localparam int W  = TRIG_BITS + 2;
	localparam int SH = phk_pkg::CORDIC_FRAC - TRIG_BITS;
	localparam logic signed [XW-1:0] HALF = XW'(64'sd1 <<< (SH - 1));
	localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1 <<< 30);
	localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'sd1 <<< 31);

	logic signed [XW-1:0] x_q [0:N];
	logic signed [XW-1:0] y_q [0:N];
	logic signed [ZW-1:0] z_q [0:N];
	logic                 f_q [0:N];

	logic signed [ZW-1:0] z_in;
	logic signed [ZW-1:0] z_fold;
	logic                 f_fold;
	logic signed [XW-1:0] x_fin;
	logic signed [XW-1:0] y_fin;
	logic signed [XW-1:0] x_rnd;
	logic signed [XW-1:0] y_rnd;

	// Fold the phase into the right half-plane
	always_comb begin
		z_in = {{2{angle[15]}}, angle, 16'b0};
		if (z_in > QUARTER) begin
			z_fold = z_in - HALF_TURN;
			f_fold = 1'b1;
		end else if (z_in < -QUARTER) begin
			z_fold = z_in + HALF_TURN;
			f_fold = 1'b1;
		end else begin
			z_fold = z_in;
			f_fold = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= phk_pkg::CORDIC_GAIN;
			y_q[0] <= '0;
			z_q[0] <= z_fold;
			f_q[0] <= f_fold;
		end
	end

	// One micro-rotation per stage
	for (genvar gi = 0; gi < N; gi++) begin : g_step
		localparam logic signed [ZW-1:0] ATAN = ZW'(phk_pkg::atan_phase(gi));
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_q[gi][ZW-1]) begin
					x_q[gi+1] <= x_q[gi] - (y_q[gi] >>> gi);
					y_q[gi+1] <= y_q[gi] + (x_q[gi] >>> gi);
					z_q[gi+1] <= z_q[gi] - ATAN;
				end else begin
					x_q[gi+1] <= x_q[gi] + (y_q[gi] >>> gi);
					y_q[gi+1] <= y_q[gi] - (x_q[gi] >>> gi);
					z_q[gi+1] <= z_q[gi] + ATAN;
				end
				f_q[gi+1] <= f_q[gi];
			end
		end
	end

	// Undo the fold and round to the output precision
	always_comb begin
		x_fin = f_q[N] ? -x_q[N] : x_q[N];
		y_fin = f_q[N] ? -y_q[N] : y_q[N];
		x_rnd = x_fin + HALF;
		y_rnd = y_fin + HALF;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_val <= x_rnd[SH+W-1:SH];
			sin_val <= y_rnd[SH+W-1:SH];
		end
	end

endmodule

`default_nettype wire

/* rtl/phk_front.sv */
// Front end: accepts items, runs both CORDICs and lines up speed and rates.
`default_nettype none

module phk_front #(
	parameter int TRIG_BITS = phk_pkg::TRIG_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [phk_pkg::SPEED_W-1:0]   speed,
	input  wire logic signed [15:0]            pitch_angle,
	input  wire logic signed [15:0]            heading_angle,
	input  wire logic signed [phk_pkg::RATE_W-1:0] pitch_rate,
	input  wire logic signed [phk_pkg::RATE_W-1:0] heading_rate,
	input  wire logic                          q_full,
	output logic                               push,
	output logic [phk_pkg::SPEED_W-1:0]        f_speed,
	output logic signed [TRIG_BITS+1:0]        f_sp,
	output logic signed [TRIG_BITS+1:0]        f_cp,
	output logic signed [TRIG_BITS+1:0]        f_sh,
	output logic signed [TRIG_BITS+1:0]        f_ch,
	output logic signed [phk_pkg::RATE_W-1:0]  f_q,
	output logic signed [phk_pkg::RATE_W-1:0]  f_r
);

	localparam int L = phk_pkg::FRONT_LAT;

	logic                               v_q   [0:L-1];
	logic [phk_pkg::SPEED_W-1:0]        spd_q [0:L-1];
	logic signed [phk_pkg::RATE_W-1:0]  pr_q  [0:L-1];
	logic signed [phk_pkg::RATE_W-1:0]  hr_q  [0:L-1];
	logic                               en;

	// Advance unless a finished item has nowhere to go
	assign en       = !v_q[L-1] || !q_full;
	assign in_stall = !en;
	assign push     = v_q[L-1] && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < L; i++) begin
				v_q[i] <= 1'b0;
			end
		end else if (en) begin
			v_q[0] <= in_valid;
			for (int i = 1; i < L; i++) begin
				v_q[i] <= v_q[i-1];
			end
		end
	end

	// Carry speed and rates alongside the CORDIC stages
	always_ff @(posedge clk) begin
		if (en) begin
			spd_q[0] <= speed;
			pr_q[0]  <= pitch_rate;
			hr_q[0]  <= heading_rate;
			for (int i = 1; i < L; i++) begin
				spd_q[i] <= spd_q[i-1];
				pr_q[i]  <= pr_q[i-1];
				hr_q[i]  <= hr_q[i-1];
			end
		end
	end

	phk_cordic #(.TRIG_BITS(TRIG_BITS)) u_pitch (
		.clk     (clk),
		.en      (en),
		.angle   (pitch_angle),
		.sin_val (f_sp),
		.cos_val (f_cp)
	);

	phk_cordic #(.TRIG_BITS(TRIG_BITS)) u_heading (
		.clk     (clk),
		.en      (en),
		.angle   (heading_angle),
		.sin_val (f_sh),
		.cos_val (f_ch)
	);

	assign f_speed = spd_q[L-1];
	assign f_q     = pr_q[L-1];
	assign f_r     = hr_q[L-1];

endmodule

`default_nettype wire

/* rtl/phk_queue.sv */
// Short FIFO between the trig front end and the multiply back end.
`default_nettype none

module phk_queue #(
	parameter int DW    = 8,
	parameter int DEPTH = phk_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          pop,
	output logic [DW-1:0]      rdata,
	output logic               full,
	output logic               empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] mem_q [0:DEPTH-1];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/phk_back.sv */
// Back end: products, rounding and saturation for velocity and acceleration.
`default_nettype none

module phk_back #(
	parameter int TRIG_BITS = phk_pkg::TRIG_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_empty,
	output logic                               pop,
	input  wire logic [phk_pkg::SPEED_W-1:0]   h_speed,
	input  wire logic signed [TRIG_BITS+1:0]   h_sp,
	input  wire logic signed [TRIG_BITS+1:0]   h_cp,
	input  wire logic signed [TRIG_BITS+1:0]   h_sh,
	input  wire logic signed [TRIG_BITS+1:0]   h_ch,
	input  wire logic signed [phk_pkg::RATE_W-1:0] h_q,
	input  wire logic signed [phk_pkg::RATE_W-1:0] h_r,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [phk_pkg::VEL_W-1:0]          vel_north,
	output logic [phk_pkg::VEL_W-1:0]          vel_east,
	output logic [phk_pkg::VEL_W-1:0]          vel_down,
	output logic [phk_pkg::ACC_W-1:0]          acc_north,
	output logic [phk_pkg::ACC_W-1:0]          acc_east,
	output logic [phk_pkg::ACC_W-1:0]          acc_down,
	output logic                               saturated
);

	localparam int TB   = TRIG_BITS;
	localparam int W    = TB + 2;
	localparam int SW   = phk_pkg::SPEED_W + 1;
	localparam int RW   = phk_pkg::RATE_W;
	localparam int HW   = 21;
	localparam int DDW  = 25;
	localparam int DNW  = 26;
	localparam int SUMW = W + RW + 1;
	localparam int ASH  = phk_pkg::ACC_SH;
	localparam logic signed [63:0] HALF_T = 64'sd1 <<< (TB - 1);
	localparam logic signed [63:0] HALF_A = 64'sd1 <<< (ASH - 1);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// Stage 1: head of the queue
	logic signed [SW-1:0] spd_s1;
	logic signed [W-1:0]  sp_s1, cp_s1, sh_s1, ch_s1;
	logic signed [RW-1:0] q_s1, r_s1;
	// Stage 2: first products
	logic signed [SW+W-1:0] hs_p_s2, vd_p_s2;
	logic signed [2*W-1:0]  p1_s2, p2_s2, p3_s2, p4_s2;
	logic signed [W+RW-1:0] dd_p_s2;
	logic signed [SW-1:0]   spd_s2;
	logic signed [W-1:0]    sh_s2, ch_s2;
	logic signed [RW-1:0]   q_s2, r_s2;
	// Stage 3: rounded
	logic signed [HW-1:0]   hs_s3;
	logic [phk_pkg::VEL_W-1:0] vd_s3;
	logic signed [W-1:0]    t1_s3, t2_s3, t3_s3, t4_s3;
	logic signed [DDW-1:0]  dd_s3;
	logic signed [SW-1:0]   spd_s3;
	logic signed [W-1:0]    sh_s3, ch_s3;
	logic signed [RW-1:0]   q_s3, r_s3;
	// Stage 4: second products
	logic signed [HW+W-1:0] vn_p_s4, ve_p_s4;
	logic signed [W+RW-1:0] a1_s4, a2_s4, a3_s4, a4_s4;
	logic signed [SW+DDW-1:0] ad_p_s4;
	logic signed [SW-1:0]   spd_s4;
	logic [phk_pkg::VEL_W-1:0] vd_s4;
	// Stage 5: direction rates and velocities
	logic signed [DNW-1:0]  dn_s5, de_s5;
	logic [phk_pkg::VEL_W-1:0] vn_s5, ve_s5, vd_s5;
	logic [phk_pkg::ACC_W-1:0] ad_s5;
	logic                   adh_s5;
	logic signed [SW-1:0]   spd_s5;
	// Stage 6: acceleration products
	logic signed [SW+DNW-1:0] an_p_s6, ae_p_s6;
	logic [phk_pkg::VEL_W-1:0] vn_s6, ve_s6, vd_s6;
	logic [phk_pkg::ACC_W-1:0] ad_s6;
	logic                   adh_s6;

	// Rounding intermediates
	logic signed [SW+W-1:0]   hs_r, vd_r;
	logic signed [2*W-1:0]    p1_r, p2_r, p3_r, p4_r;
	logic signed [W+RW-1:0]   dd_r;
	logic signed [31:0]       vd_neg;
	logic signed [HW+W-1:0]   vn_r, ve_r;
	logic signed [SUMW-1:0]   sum_n, sum_e, sum_nr, sum_er;
	logic signed [SW+DDW-1:0] ad_r;
	logic [phk_pkg::ACC_W:0]  ad_sat;
	logic signed [SW+DNW-1:0] an_r, ae_r;
	logic [phk_pkg::ACC_W:0]  an_sat, ae_sat;

	// Hold everything while the output is stalled
	assign en  = !(v_s7 && out_stall);
	assign pop = en && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Round products back to trig or field precision
	always_comb begin
		hs_r   = hs_p_s2 + (SW+W)'(HALF_T);
		vd_r   = vd_p_s2 + (SW+W)'(HALF_T);
		p1_r   = p1_s2 + (2*W)'(HALF_T);
		p2_r   = p2_s2 + (2*W)'(HALF_T);
		p3_r   = p3_s2 + (2*W)'(HALF_T);
		p4_r   = p4_s2 + (2*W)'(HALF_T);
		dd_r   = dd_p_s2 + (W+RW)'(HALF_T);
		vd_neg = -(32'($signed(vd_r[TB+HW-1:TB])));

		vn_r   = vn_p_s4 + (HW+W)'(HALF_T);
		ve_r   = ve_p_s4 + (HW+W)'(HALF_T);
		sum_n  = -(SUMW'(a1_s4)) - SUMW'(a2_s4);
		sum_e  = -(SUMW'(a3_s4)) + SUMW'(a4_s4);
		sum_nr = sum_n + SUMW'(HALF_T);
		sum_er = sum_e + SUMW'(HALF_T);
		ad_r   = ad_p_s4 + (SW+DDW)'(HALF_A);
		ad_sat = phk_pkg::sat_acc(-(64'($signed(ad_r[SW+DDW-1:ASH]))));

		an_r   = an_p_s6 + (SW+DNW)'(HALF_A);
		ae_r   = ae_p_s6 + (SW+DNW)'(HALF_A);
		an_sat = phk_pkg::sat_acc(64'($signed(an_r[SW+DNW-1:ASH])));
		ae_sat = phk_pkg::sat_acc(64'($signed(ae_r[SW+DNW-1:ASH])));
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			spd_s1 <= $signed({1'b0, h_speed});
			sp_s1  <= h_sp;
			cp_s1  <= h_cp;
			sh_s1  <= h_sh;
			ch_s1  <= h_ch;
			q_s1   <= h_q;
			r_s1   <= h_r;

			hs_p_s2 <= spd_s1 * cp_s1;
			vd_p_s2 <= spd_s1 * sp_s1;
			p1_s2   <= sp_s1 * ch_s1;
			p2_s2   <= cp_s1 * sh_s1;
			p3_s2   <= sp_s1 * sh_s1;
			p4_s2   <= cp_s1 * ch_s1;
			dd_p_s2 <= cp_s1 * q_s1;
			spd_s2  <= spd_s1;
			sh_s2   <= sh_s1;
			ch_s2   <= ch_s1;
			q_s2    <= q_s1;
			r_s2    <= r_s1;

			hs_s3  <= hs_r[TB+HW-1:TB];
			vd_s3  <= phk_pkg::sat_vel(vd_neg);
			t1_s3  <= p1_r[TB+W-1:TB];
			t2_s3  <= p2_r[TB+W-1:TB];
			t3_s3  <= p3_r[TB+W-1:TB];
			t4_s3  <= p4_r[TB+W-1:TB];
			dd_s3  <= dd_r[TB+DDW-1:TB];
			spd_s3 <= spd_s2;
			sh_s3  <= sh_s2;
			ch_s3  <= ch_s2;
			q_s3   <= q_s2;
			r_s3   <= r_s2;

			vn_p_s4 <= hs_s3 * ch_s3;
			ve_p_s4 <= hs_s3 * sh_s3;
			a1_s4   <= t1_s3 * q_s3;
			a2_s4   <= t2_s3 * r_s3;
			a3_s4   <= t3_s3 * q_s3;
			a4_s4   <= t4_s3 * r_s3;
			ad_p_s4 <= spd_s3 * dd_s3;
			spd_s4  <= spd_s3;
			vd_s4   <= vd_s3;

			dn_s5  <= sum_nr[TB+DNW-1:TB];
			de_s5  <= sum_er[TB+DNW-1:TB];
			vn_s5  <= phk_pkg::sat_vel(32'($signed(vn_r[TB+HW-1:TB])));
			ve_s5  <= phk_pkg::sat_vel(32'($signed(ve_r[TB+HW-1:TB])));
			vd_s5  <= vd_s4;
			ad_s5  <= ad_sat[phk_pkg::ACC_W-1:0];
			adh_s5 <= ad_sat[phk_pkg::ACC_W];
			spd_s5 <= spd_s4;

			an_p_s6 <= spd_s5 * dn_s5;
			ae_p_s6 <= spd_s5 * de_s5;
			vn_s6   <= vn_s5;
			ve_s6   <= ve_s5;
			vd_s6   <= vd_s5;
			ad_s6   <= ad_s5;
			adh_s6  <= adh_s5;

			vel_north <= vn_s6;
			vel_east  <= ve_s6;
			vel_down  <= vd_s6;
			acc_north <= an_sat[phk_pkg::ACC_W-1:0];
			acc_east  <= ae_sat[phk_pkg::ACC_W-1:0];
			acc_down  <= ad_s6;
			saturated <= an_sat[phk_pkg::ACC_W] | ae_sat[phk_pkg::ACC_W] | adh_s6;
		end
	end

	assign out_valid = v_s7;

endmodule

`default_nettype wire

/* sim/pitch_heading_kinematics_tb.sv */
// Self-checking testbench for the speed/pitch/heading to NED kinematics block.
`default_nettype none

module pitch_heading_kinematics_tb;

	localparam int TB = phk_pkg::TRIG_BITS_DEF;
	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_ITEMS = 1800;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic [phk_pkg::SPEED_W-1:0]        spd;
		logic signed [phk_pkg::ANGLE_W-1:0] pa;
		logic signed [phk_pkg::ANGLE_W-1:0] ha;
		logic signed [phk_pkg::RATE_W-1:0]  q;
		logic signed [phk_pkg::RATE_W-1:0]  r;
	} kin_in_t;

	typedef struct {
		logic signed [phk_pkg::VEL_W-1:0] vn, ve, vd;
		logic signed [phk_pkg::ACC_W-1:0] an, ae, ad;
		logic                             sat;
	} kin_out_t;

	// directed row: input plus an optional hand-typed result
	typedef struct {
		kin_in_t  stim;
		bit       typed;
		kin_out_t res;
	} kin_row_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [phk_pkg::SPEED_W-1:0] speed;
	logic signed [phk_pkg::ANGLE_W-1:0] pitch_angle, heading_angle;
	logic signed [phk_pkg::RATE_W-1:0] pitch_rate, heading_rate;
	logic signed [phk_pkg::VEL_W-1:0] vel_north, vel_east, vel_down;
	logic signed [phk_pkg::ACC_W-1:0] acc_north, acc_east, acc_down;
	logic saturated;

	kin_out_t expected_q[$];
	int mismatches = 0;
	int checked = 0;
	int sat_seen = 0;
	int cycles = 0;
	bit calm = 0;
	kin_in_t cur;

	pitch_heading_kinematics dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.speed(speed), .pitch_angle(pitch_angle), .heading_angle(heading_angle),
		.pitch_rate(pitch_rate), .heading_rate(heading_rate),
		.out_valid(out_valid), .out_stall(out_stall),
		.vel_north(vel_north), .vel_east(vel_east), .vel_down(vel_down),
		.acc_north(acc_north), .acc_east(acc_east), .acc_down(acc_down),
		.saturated(saturated)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Round half up, arithmetic shift
	function automatic longint round_sh(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	// CORDIC sine/cosine of a binary angle, rounded to Q(TB)
	function automatic void sin_cos(input logic signed [phk_pkg::ANGLE_W-1:0] ang,
			output longint s, output longint c);
		longint z, x, y, nx;
		bit flip;
		z = longint'(ang) * 65536;
		x = 652032874;
		y = 0;
		flip = 0;
		if (z > (longint'(1) << 30)) begin
			z -= longint'(1) << 31;
			flip = 1;
		end else if (z < -(longint'(1) << 30)) begin
			z += longint'(1) << 31;
			flip = 1;
		end
		for (int i = 0; i < phk_pkg::CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(phk_pkg::atan_phase(i));
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(phk_pkg::atan_phase(i));
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = round_sh(x, phk_pkg::CORDIC_FRAC - TB);
		s = round_sh(y, phk_pkg::CORDIC_FRAC - TB);
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi, ref bit hit);
		if (v < lo) begin
			hit = 1;
			return lo;
		end
		if (v > hi) begin
			hit = 1;
			return hi;
		end
		return v;
	endfunction

	// Predict velocity and feedforward acceleration for one sample
	function automatic kin_out_t predict_kinematics(kin_in_t t);
		longint spd, sp, cp, sh, ch, hs, dn, de, dd;
		longint q, r;
		bit vh, ah;
		kin_out_t o;
		spd = longint'(t.spd);
		q = longint'(t.q);
		r = longint'(t.r);
		vh = 0;
		ah = 0;
		sin_cos(t.pa, sp, cp);
		sin_cos(t.ha, sh, ch);
		hs = round_sh(spd * cp, TB);
		o.vn = phk_pkg::VEL_W'(clip(round_sh(hs * ch, TB), -524288, 524287, vh));
		o.ve = phk_pkg::VEL_W'(clip(round_sh(hs * sh, TB), -524288, 524287, vh));
		o.vd = phk_pkg::VEL_W'(clip(-round_sh(spd * sp, TB), -524288, 524287, vh));
		dn = round_sh(-round_sh(sp * ch, TB) * q - round_sh(cp * sh, TB) * r, TB);
		de = round_sh(-round_sh(sp * sh, TB) * q + round_sh(cp * ch, TB) * r, TB);
		dd = round_sh(cp * q, TB);
		o.an = phk_pkg::ACC_W'(clip(round_sh(spd * dn, 16),
			-64'sd2147483648, 64'sd2147483647, ah));
		o.ae = phk_pkg::ACC_W'(clip(round_sh(spd * de, 16),
			-64'sd2147483648, 64'sd2147483647, ah));
		o.ad = phk_pkg::ACC_W'(clip(-round_sh(spd * dd, 16),
			-64'sd2147483648, 64'sd2147483647, ah));
		o.sat = ah;
		return o;
	endfunction

	function automatic kin_in_t random_sample();
		kin_in_t t;
		int k;
		t.spd = phk_pkg::SPEED_W'($urandom);
		t.pa = phk_pkg::ANGLE_W'($urandom);
		t.ha = phk_pkg::ANGLE_W'($urandom);
		t.q = phk_pkg::RATE_W'($urandom);
		t.r = phk_pkg::RATE_W'($urandom);
		k = $urandom_range(0, 9);
		// realistic rates half the time, full-scale rates otherwise
		if (k < 5) begin
			t.q = phk_pkg::RATE_W'($signed($urandom_range(0, 131071)) - 65536);
			t.r = phk_pkg::RATE_W'($signed($urandom_range(0, 131071)) - 65536);
		end else if (k == 6) begin
			t.spd = {phk_pkg::SPEED_W{1'b1}};
		end else if (k == 7) begin
			t.pa = {3'($urandom_range(0, 7)), 13'd0};
			t.ha = {3'($urandom_range(0, 7)), 13'd0};
		end
		return t;
	endfunction

	function automatic kin_in_t mk(int s, int p, int h, int q, int r);
		kin_in_t t;
		t.spd = phk_pkg::SPEED_W'(s);
		t.pa = phk_pkg::ANGLE_W'(p);
		t.ha = phk_pkg::ANGLE_W'(h);
		t.q = phk_pkg::RATE_W'(q);
		t.r = phk_pkg::RATE_W'(r);
		return t;
	endfunction

	// Offer one sample; hold it until the transfer happens
	task automatic send_sample(kin_in_t t);
		while (!calm && $urandom_range(0, 99) < 26) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		speed <= t.spd;
		pitch_angle <= t.pa;
		heading_angle <= t.ha;
		pitch_rate <= t.q;
		heading_rate <= t.r;
		cur = t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Record the expectation at the accepting edge
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			expected_q.push_back(predict_kinematics(cur));
		end
	end

	// Check each output transfer against the oldest expectation
	always @(posedge clk) begin
		kin_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected output transfer");
			end else begin
				e = expected_q.pop_front();
				checked++;
				if (saturated) sat_seen++;
				if (vel_north !== e.vn || vel_east !== e.ve || vel_down !== e.vd ||
						acc_north !== e.an || acc_east !== e.ae || acc_down !== e.ad ||
						saturated !== e.sat) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch exp v=%0d %0d %0d a=%0d %0d %0d s=%0b",
							e.vn, e.ve, e.vd, e.an, e.ae, e.ad, e.sat);
						$display("         got v=%0d %0d %0d a=%0d %0d %0d s=%0b",
							vel_north, vel_east, vel_down, acc_north, acc_east,
							acc_down, saturated);
					end
				end
			end
		end
	end

	// Drive receiver stalls; one long hold-off fills the block
	initial begin
		out_stall = 0;
		@(posedge arst_n);
		repeat (400) begin
			@(negedge clk);
			out_stall <= (!calm && $urandom_range(0, 99) < 26);
		end
		@(negedge clk);
		out_stall <= 1;
		repeat (300) @(negedge clk);
		forever begin
			@(negedge clk);
			out_stall <= (!calm && $urandom_range(0, 99) < 26);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		kin_row_t rows[$];
		kin_row_t row;
		kin_out_t z;
		in_valid = 0;
		speed = 0;
		pitch_angle = 0;
		heading_angle = 0;
		pitch_rate = 0;
		heading_rate = 0;
		arst_n = 0;
		z = '{default: 0};
		// all-zero input gives all-zero result
		row.stim = mk(0, 0, 0, 0, 0); row.typed = 1; row.res = z; rows.push_back(row);
		// zero speed with extreme rates: still zero
		row.stim = mk(0, -32768, 32767, -8388608, 8388607); row.typed = 1; row.res = z;
		rows.push_back(row);
		row.typed = 0;
		row.stim = mk(524287, 0, 0, 0, 0); rows.push_back(row);
		row.stim = mk(524287, 16384, 0, 0, 0); rows.push_back(row);
		row.stim = mk(524287, -16384, 0, 0, 0); rows.push_back(row);
		row.stim = mk(524287, -32768, -32768, 0, 0); rows.push_back(row);
		row.stim = mk(524287, 0, 16384, 0, 0); rows.push_back(row);
		row.stim = mk(524287, 0, -16384, 0, 0); rows.push_back(row);
		row.stim = mk(524287, 8192, 8192, 0, 0); rows.push_back(row);
		row.stim = mk(524287, 32767, 32767, 0, 0); rows.push_back(row);
		// full-scale speed and rate cases
		row.stim = mk(524287, 0, 0, 8388607, 8388607); rows.push_back(row);
		row.stim = mk(524287, 0, 0, -8388608, -8388608); rows.push_back(row);
		row.stim = mk(524287, 16384, 16384, 8388607, -8388608); rows.push_back(row);
		row.stim = mk(524287, -8192, 24576, -8388608, 8388607); rows.push_back(row);
		row.stim = mk(256, 0, 0, 65536, 65536); rows.push_back(row);
		row.stim = mk(1, 1, -1, 1, -1); rows.push_back(row);
		row.stim = mk(300000, 12000, -20000, 70000, -50000); rows.push_back(row);
		row.stim = mk(524287, -1, 1, -1, 1); rows.push_back(row);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed table
		foreach (rows[i]) begin
			send_sample(rows[i].stim);
			if (rows[i].typed) begin
				expected_q[expected_q.size() - 1] = rows[i].res;
			end
		end
		// random samples, with a calm stretch in the middle
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= 900 && n < 1100);
			send_sample(random_sample());
		end
		in_valid <= 0;
		calm = 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("checked %0d results (%0d directed), %0d with saturated acceleration",
			checked, rows.size(), sat_seen);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
